@@ src/psg_pkg.sv @@
// Shared types and constants for the pulse/saw sound generator.
// No dependencies; imported by psg_decode and pulse_saw_sound_generator_unit.
package psg_pkg;

  localparam int unsigned MAX_TICKS = 16;
  localparam int unsigned CNT_W     = 14;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SRST  = 2'd2;

  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_PLO  = 2'd1;
  localparam logic [1:0] REG_PHI  = 2'd2;
  localparam logic [1:0] REG_MSTR = 2'd3;

  localparam logic [1:0] CH_PA  = 2'd0;
  localparam logic [1:0] CH_PB  = 2'd1;
  localparam logic [1:0] CH_SAW = 2'd2;

  localparam logic [3:0] PAGE_PA  = 4'h9;
  localparam logic [3:0] PAGE_PB  = 4'hA;
  localparam logic [3:0] PAGE_SAW = 4'hB;

  localparam logic [3:0] SAW_WRAP = 4'd14;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [4:0]  tick_count;
    logic        audio_on;
  } in_t;

  typedef struct packed {
    logic [3:0] pulse_a_level;
    logic [3:0] pulse_b_level;
    logic [5:0] saw_level;
  } out_t;

  typedef struct packed {
    logic       chan_we;
    logic       master_we;
    logic [1:0] chan;
    logic [1:0] regsel;
  } dec_t;

endpackage

@@ src/psg_decode.sv @@
// Bus address decoder for the sound generator register map.
// Depends on psg_pkg (dec_t, page and register codes).
module psg_decode import psg_pkg::*; (
  input  logic [15:0] address_i,
  input  logic        swap_i,
  output dec_t        dec_o
);

  logic [1:0] low;

  always_comb begin
    low = address_i[1:0];
    if (swap_i && (low == 2'd1 || low == 2'd2)) begin
      low = low ^ 2'b11;
    end
    dec_o           = '0;
    dec_o.regsel    = low;
    unique case (address_i[15:12])
      PAGE_PA: begin
        if (low == REG_MSTR) begin
          dec_o.master_we = 1'b1;
        end else begin
          dec_o.chan_we = 1'b1;
          dec_o.chan    = CH_PA;
        end
      end
      PAGE_PB: begin
        dec_o.chan_we = (low != REG_MSTR);
        dec_o.chan    = CH_PB;
      end
      PAGE_SAW: begin
        dec_o.chan_we = (low != REG_MSTR);
        dec_o.chan    = CH_SAW;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/pulse_saw_sound_generator_unit.sv @@
// Pulse/saw sound generator top level: handshakes, channel registers and sequencer.
// Depends on psg_pkg and psg_decode.

// A register write, a soft reset or an unused command gives no result. A tick
// item with audio off or the halt bit set goes straight to the done state and
// gives a zero result. An advancing tick item updates the three channels before
// its result is offered, with 0 to 17 counter reloads per channel: one shared
// 14-bit add/compare unit walks the channels in turn, with a subtract step for
// each, then a reload step per reload and a closing step for the channel. The
// block is not ready while a tick is in progress; a finished result waits in the
// output register while the next item is accepted.
module pulse_saw_sound_generator_unit import psg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_swap_lines_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SUB    = 4'b0010,
    S_RELOAD = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q;

  logic             swap_q;
  logic             halt_q;
  logic [1:0]       shift_q;
  logic [3:0]       vol_q   [2];
  logic [3:0]       duty_q  [2];
  logic [3:0]       dstep_q [2];
  logic [3:0]       lev_q   [2];
  logic [11:0]      period_q[3];
  logic [CNT_W-1:0] cnt_q   [3];
  logic             en_q    [3];
  logic [5:0]       saw_rate_q;
  logic [3:0]       saw_step_q;
  logic [8:0]       saw_accum_q;
  logic [1:0]       ch_q;
  logic [4:0]       t_q;
  logic             run_q;
  logic             out_valid_q;
  out_t             out_q;

  dec_t             dec;
  logic             in_acc;
  logic [4:0]       t_sat;
  logic [11:0]      per_shifted;
  logic [12:0]      reload;
  logic [CNT_W-1:0] cnt_sel;
  logic [CNT_W-1:0] addend;
  logic [CNT_W-1:0] sum;
  logic             need_reload;
  logic [3:0]       saw_step_inc;
  logic [3:0]       saw_step_d;
  logic [8:0]       saw_accum_d;
  logic             pidx;

  psg_decode u_decode (
    .address_i (in_data_i.address),
    .swap_i    (swap_q),
    .dec_o     (dec)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pidx        = ch_q[0];

  always_comb begin
    if (int'(in_data_i.tick_count) > MAX_TICKS) begin
      t_sat = 5'(MAX_TICKS);
    end else begin
      t_sat = in_data_i.tick_count;
    end
  end

  // shared counter unit: subtract the ticks, then add reloads until positive
  always_comb begin
    cnt_sel = cnt_q[ch_q];
    case (shift_q)
      2'd0:    per_shifted = period_q[ch_q];
      2'd1:    per_shifted = period_q[ch_q] >> 4;
      default: per_shifted = period_q[ch_q] >> 8;
    endcase
    reload      = {1'b0, per_shifted} + 13'd1;
    addend      = (state_q == S_SUB) ? (-{{(CNT_W-5){1'b0}}, t_q})
                                     : {{(CNT_W-13){1'b0}}, reload};
    sum         = cnt_sel + addend;
    need_reload = cnt_sel[CNT_W-1] || (cnt_sel == '0);
  end

  always_comb begin
    saw_step_inc = saw_step_q + 4'd1;
    saw_step_d   = saw_step_inc;
    saw_accum_d  = saw_accum_q;
    if (saw_step_inc >= SAW_WRAP) begin
      saw_step_d  = '0;
      saw_accum_d = '0;
    end else if (!saw_step_inc[0]) begin
      saw_accum_d = saw_accum_q + {3'd0, saw_rate_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      swap_q      <= 1'b0;
      halt_q      <= 1'b0;
      shift_q     <= '0;
      saw_rate_q  <= '0;
      saw_step_q  <= '0;
      saw_accum_q <= '0;
      ch_q        <= CH_PA;
      t_q         <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 2; i++) begin
        vol_q[i]   <= '0;
        duty_q[i]  <= '0;
        dstep_q[i] <= '0;
        lev_q[i]   <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        period_q[i] <= 12'hFFF;
        cnt_q[i]    <= '0;
        en_q[i]     <= 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        swap_q <= cfg_swap_lines_i;
      end
      // in S_DONE the output register is reloaded below instead
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data_i.command)
              CMD_WRITE: begin
                if (dec.master_we) begin
                  halt_q <= in_data_i.data[0];
                  if (in_data_i.data[2]) begin
                    shift_q <= 2'd2;
                  end else if (in_data_i.data[1]) begin
                    shift_q <= 2'd1;
                  end else begin
                    shift_q <= 2'd0;
                  end
                end
                if (dec.chan_we) begin
                  unique case (dec.regsel)
                    REG_CTRL: begin
                      if (dec.chan == CH_SAW) begin
                        saw_rate_q <= in_data_i.data[5:0];
                      end else begin
                        vol_q[dec.chan[0]]  <= in_data_i.data[3:0];
                        duty_q[dec.chan[0]] <= in_data_i.data[7] ? 4'hF
                                               : {1'b0, in_data_i.data[6:4]};
                      end
                    end
                    REG_PLO: begin
                      period_q[dec.chan][7:0] <= in_data_i.data;
                    end
                    REG_PHI: begin
                      period_q[dec.chan][11:8] <= in_data_i.data[3:0];
                      en_q[dec.chan]           <= in_data_i.data[7];
                      if (!in_data_i.data[7]) begin
                        if (dec.chan == CH_SAW) begin
                          saw_step_q  <= '0;
                          saw_accum_q <= '0;
                        end else begin
                          dstep_q[dec.chan[0]] <= '0;
                        end
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
              CMD_TICK: begin
                t_q  <= t_sat;
                ch_q <= CH_PA;
                if (in_data_i.audio_on && !halt_q) begin
                  run_q   <= 1'b1;
                  state_q <= S_SUB;
                end else begin
                  run_q    <= 1'b0;
                  lev_q[0] <= '0;
                  lev_q[1] <= '0;
                  state_q  <= S_DONE;
                end
              end
              CMD_SRST: begin
                for (int i = 0; i < 3; i++) begin
                  en_q[i] <= 1'b0;
                end
                dstep_q[0]  <= '0;
                dstep_q[1]  <= '0;
                saw_step_q  <= '0;
                saw_accum_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SUB: begin
          cnt_q[ch_q] <= sum;
          state_q     <= S_RELOAD;
        end
        S_RELOAD: begin
          if (need_reload) begin
            cnt_q[ch_q] <= sum;
            if (en_q[ch_q]) begin
              if (ch_q == CH_SAW) begin
                saw_step_q  <= saw_step_d;
                saw_accum_q <= saw_accum_d;
              end else begin
                dstep_q[pidx] <= dstep_q[pidx] + 4'd1;
              end
            end
          end else if (ch_q == CH_SAW) begin
            state_q <= S_DONE;
          end else begin
            lev_q[pidx] <= (en_q[ch_q] && (dstep_q[pidx] <= duty_q[pidx]))
                           ? vol_q[pidx] : 4'd0;
            ch_q        <= ch_q + 2'd1;
            state_q     <= S_SUB;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.pulse_a_level <= lev_q[0];
            out_q.pulse_b_level <= lev_q[1];
            out_q.saw_level     <= run_q ? saw_accum_q[8:3] : 6'd0;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a reload cycle is always followed by another look at the same channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELOAD && need_reload) |=> (state_q == S_RELOAD && $stable(ch_q)))
    else $error("reload loop left early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |=> (state_q == S_RELOAD && $stable(ch_q)))
    else $error("subtract not followed by reload check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    saw_step_q < SAW_WRAP)
    else $error("saw step out of range");

  // six adds of at most 63 between clears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    saw_accum_q <= 9'd378)
    else $error("saw accumulator beyond its reachable range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while output busy");

endmodule
